// ===== rtl/fkc_pkg.sv =====
// shared constants, types and fixed-point helpers for the fenton-karma cable cell update
package fkc_pkg;

    localparam int DATA_WIDTH_DEF       = 32;
    localparam int TANH_TABLE_DEPTH_DEF = 256;

    // registers from the item input to the result strobe
    localparam int PIPE_DEPTH = 8;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIME_STEP     = 3'd0,
        REG_STIM_CURRENT  = 3'd1,
        REG_RATE_V1_MINUS = 3'd2,
        REG_RATE_V2_MINUS = 3'd3,
        REG_RATE_SI       = 3'd4,
        REG_RATE_R        = 3'd5,
        REG_DIFF_GAIN     = 3'd6
    } cfg_reg_t;

    localparam logic [30:0]        RST_TIME_STEP     = 31'd167772;
    localparam logic signed [31:0] RST_STIM_CURRENT  = -32'sd3355443;
    localparam logic [30:0]        RST_RATE_V1_MINUS = 31'd308858;
    localparam logic [30:0]        RST_RATE_V2_MINUS = 31'd36146;
    localparam logic [30:0]        RST_RATE_SI       = 31'd396233;
    localparam logic [30:0]        RST_RATE_R        = 31'd503366;
    localparam logic [30:0]        RST_DIFF_GAIN     = 31'd260885709;

    // Q3.28 model constants
    localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;
    localparam logic signed [63:0] U_C     = 64'sd34896609;
    localparam logic signed [63:0] U_V     = 64'sd10737418;
    localparam logic signed [63:0] U_CSI   = 64'sd228170138;

    // Q8.24 rate constants
    localparam logic signed [31:0] RATE_V_PLUS  = 32'sd5038203;
    localparam logic signed [31:0] RATE_W_MINUS = 32'sd409200;
    localparam logic signed [31:0] RATE_W_PLUS  = 32'sd19284;
    localparam logic signed [31:0] RATE_D       = 32'sd167772160;
    localparam logic signed [31:0] RATE_O       = 32'sd1342177;

    localparam logic signed [63:0] GAIN_K  = 64'sd10;
    localparam logic signed [63:0] REST_MV = -64'sd82;
    localparam logic signed [63:0] SPAN_MV = 64'sd117;

    // clamp to the signed range of sb bits
    function automatic logic signed [31:0] sat_w(input logic signed [63:0] x, input int sb);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [63:0] r;
        hi = (64'sd1 <<< (sb - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi)
            r = hi;
        else if (x < lo)
            r = lo;
        else
            r = x;
        return r[31:0];
    endfunction

    function automatic logic signed [31:0] mul24(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input int sb);
        logic signed [63:0] pa;
        logic signed [63:0] pb;
        logic signed [63:0] p;
        pa = 64'(a);
        pb = 64'(b);
        p  = pa * pb;
        return sat_w(p >>> 24, sb);
    endfunction

    function automatic logic signed [31:0] mul28(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input int sb);
        logic signed [63:0] pa;
        logic signed [63:0] pb;
        logic signed [63:0] p;
        pa = 64'(a);
        pb = 64'(b);
        p  = pa * pb;
        return sat_w(p >>> 28, sb);
    endfunction

    // unsigned restoring division for table building; elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // one table entry, x is the argument in Q32 units of 1/4; elaboration only
    function automatic logic [31:0] tanh_entry(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] a3;
        logic [63:0] a5;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] r;
        a  = x >> 6;
        a2 = (a * a) >> 30;
        a3 = (a2 * a) >> 30;
        a5 = (a3 * a2) >> 30;
        t  = a - udiv64(a3, 64'd3) + udiv64(64'd2 * a5, 64'd15);
        // six angle doublings
        for (int k = 0; k < 6; k++) begin
            t2 = (t * t) >> 30;
            t  = udiv64(t << 31, (64'd1 << 30) + t2);
        end
        r = t >> 2;
        return r[31:0];
    endfunction

endpackage

// ===== rtl/fenton_karma_cable_cell_update_top.sv =====
// eight-stage pipeline for one fenton-karma cable cell euler step
//
// usage: drive the cell fields and pulse start; an item is taken at every
// clock edge with start high and busy low. busy stays low, so a new item
// may enter in every cycle, one result per cycle at full rate.
// each item gives one result when it leaves the last of the eight pipeline registers:
// result_valid is high for exactly one cycle with new_potential,
// new_fast_gate, new_slow_gate and voltage_mv. the receiver cannot stall
// the pipeline, results must be taken when strobed.
// the pipeline depth is set by the chain of dependent 32x32 multiplies (gate step,
// fast current product chain, potential step, mv scaling).
// configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// cfg_index selects the register, unused indexes are dropped. write only
// while no item is in flight.
// reset: rst_n clears all pipeline valid bits and loads the default
// register values; items in flight are discarded.
module fenton_karma_cable_cell_update_top #(
    parameter int DATA_WIDTH       = fkc_pkg::DATA_WIDTH_DEF,
    parameter int TANH_TABLE_DEPTH = fkc_pkg::TANH_TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [31:0]                 potential_self,
    input  logic signed [31:0]                 potential_left,
    input  logic signed [31:0]                 potential_right,
    input  logic signed [31:0]                 fast_gate,
    input  logic signed [31:0]                 slow_gate,
    input  logic                               at_left_end,
    input  logic                               at_right_end,
    input  logic                               stimulus_on,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fkc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                        cfg_data,
    output logic                               result_valid,
    output logic signed [31:0]                 new_potential,
    output logic signed [31:0]                 new_fast_gate,
    output logic signed [31:0]                 new_slow_gate,
    output logic signed [31:0]                 voltage_mv
);

    localparam int SB    = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int IDX_W = $clog2(TANH_TABLE_DEPTH);

    typedef logic [31:0] rom_t [TANH_TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < TANH_TABLE_DEPTH; i++) begin
            r[i] = fkc_pkg::tanh_entry(fkc_pkg::udiv64(64'(i) << 32,
                                                       64'(TANH_TABLE_DEPTH)));
        end
        return r;
    endfunction

    localparam rom_t TANH_ROM = build_rom();

    // configuration registers
    logic [30:0]        time_step_reg;
    logic signed [31:0] stim_current_reg;
    logic [30:0]        rate_v1_reg;
    logic [30:0]        rate_v2_reg;
    logic [30:0]        rate_si_reg;
    logic [30:0]        rate_r_reg;
    logic [30:0]        diff_gain_reg;

    logic                       cfg_we;
    logic [fkc_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic [fkc_pkg::PIPE_DEPTH-1:0] vld_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg    <= fkc_pkg::RST_TIME_STEP;
            stim_current_reg <= fkc_pkg::RST_STIM_CURRENT;
            rate_v1_reg      <= fkc_pkg::RST_RATE_V1_MINUS;
            rate_v2_reg      <= fkc_pkg::RST_RATE_V2_MINUS;
            rate_si_reg      <= fkc_pkg::RST_RATE_SI;
            rate_r_reg       <= fkc_pkg::RST_RATE_R;
            diff_gain_reg    <= fkc_pkg::RST_DIFF_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fkc_pkg::REG_TIME_STEP:     time_step_reg    <= cfg_data[30:0];
                fkc_pkg::REG_STIM_CURRENT:  stim_current_reg <= $signed(cfg_data);
                fkc_pkg::REG_RATE_V1_MINUS: rate_v1_reg      <= cfg_data[30:0];
                fkc_pkg::REG_RATE_V2_MINUS: rate_v2_reg      <= cfg_data[30:0];
                fkc_pkg::REG_RATE_SI:       rate_si_reg      <= cfg_data[30:0];
                fkc_pkg::REG_RATE_R:        rate_r_reg       <= cfg_data[30:0];
                fkc_pkg::REG_DIFF_GAIN:     diff_gain_reg    <= cfg_data[30:0];
                default:                    ;
            endcase
        end
    end

    // valid bits travel alongside the data
    assign vld_next = {vld_reg[fkc_pkg::PIPE_DEPTH-2:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign result_valid = vld_reg[fkc_pkg::PIPE_DEPTH-1];

    logic signed [31:0] dt_s;
    assign dt_s = $signed({1'b0, time_step_reg});

    // stage 1: gate rates, tanh argument, laplacian, fixed currents
    logic               s1_above_next;
    logic signed [31:0] s1_dv_next, s1_dw_next, s1_z_next, s1_lap_next;
    logic signed [31:0] s1_iso_next, s1_istim_next;
    logic               s1_above_reg;
    logic signed [31:0] s1_u_reg, s1_v_reg, s1_w_reg;
    logic signed [31:0] s1_dv_reg, s1_dw_reg, s1_z_reg, s1_lap_reg;
    logic signed [31:0] s1_iso_reg, s1_istim_reg;

    always_comb
    begin
        logic signed [63:0] u64;
        logic signed [63:0] lap64;
        logic signed [31:0] va, vb, wa, wb, mv_, mw_, rv;
        u64   = 64'(potential_self);
        s1_above_next = u64 >= fkc_pkg::U_C;
        rv = (u64 >= fkc_pkg::U_V) ? $signed({1'b0, rate_v1_reg})
                                   : $signed({1'b0, rate_v2_reg});
        va = s1_above_next ? fast_gate
                           : fkc_pkg::sat_w(fkc_pkg::ONE_Q28 - 64'(fast_gate), SB);
        vb = s1_above_next ? fkc_pkg::RATE_V_PLUS : rv;
        wa = s1_above_next ? slow_gate
                           : fkc_pkg::sat_w(fkc_pkg::ONE_Q28 - 64'(slow_gate), SB);
        wb = s1_above_next ? fkc_pkg::RATE_W_PLUS : fkc_pkg::RATE_W_MINUS;
        mv_ = fkc_pkg::mul24(va, vb, SB);
        mw_ = fkc_pkg::mul24(wa, wb, SB);
        s1_dv_next = s1_above_next ? fkc_pkg::sat_w(-64'(mv_), SB) : mv_;
        s1_dw_next = s1_above_next ? fkc_pkg::sat_w(-64'(mw_), SB) : mw_;
        s1_z_next  = fkc_pkg::sat_w(fkc_pkg::GAIN_K * (u64 - fkc_pkg::U_CSI), SB);
        lap64 = 64'sd0;
        if (!at_left_end)
            lap64 = lap64 + 64'(potential_left) - u64;
        if (!at_right_end)
            lap64 = lap64 + 64'(potential_right) - u64;
        s1_lap_next = fkc_pkg::sat_w(lap64, SB);
        s1_iso_next = s1_above_next
                    ? fkc_pkg::sat_w(64'($signed({1'b0, rate_r_reg})) * 64'sd16, SB)
                    : fkc_pkg::mul24(potential_self, fkc_pkg::RATE_O, SB);
        s1_istim_next = stimulus_on ? fkc_pkg::sat_w(64'(stim_current_reg) * 64'sd16, SB)
                                    : 32'sd0;
    end

    always_ff @(posedge clk)
    begin
        s1_u_reg     <= potential_self;
        s1_v_reg     <= fast_gate;
        s1_w_reg     <= slow_gate;
        s1_above_reg <= s1_above_next;
        s1_dv_reg    <= s1_dv_next;
        s1_dw_reg    <= s1_dw_next;
        s1_z_reg     <= s1_z_next;
        s1_lap_reg   <= s1_lap_next;
        s1_iso_reg   <= s1_iso_next;
        s1_istim_reg <= s1_istim_next;
    end

    // stage 2: gate step, tanh lookup, diffusion term
    logic signed [31:0] s2_nv_next, s2_nw_next, s2_th_next, s2_lapd_next;
    logic               s2_above_reg;
    logic signed [31:0] s2_u_reg, s2_nv_reg, s2_nw_reg, s2_th_reg, s2_lapd_reg;
    logic signed [31:0] s2_iso_reg, s2_istim_reg;

    always_comb
    begin
        logic signed [63:0] z64;
        logic [63:0]        az;
        logic [63:0]        idx_full;
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] r;
        s2_nv_next = fkc_pkg::sat_w(64'(s1_v_reg)
                     + 64'(fkc_pkg::mul24(s1_dv_reg, dt_s, SB)), SB);
        s2_nw_next = fkc_pkg::sat_w(64'(s1_w_reg)
                     + 64'(fkc_pkg::mul24(s1_dw_reg, dt_s, SB)), SB);
        z64 = 64'(s1_z_reg);
        az  = (z64 < 0) ? 64'(-z64) : 64'(z64);
        idx_full = (az * 64'(TANH_TABLE_DEPTH)) >> 30;
        if (idx_full >= 64'(TANH_TABLE_DEPTH))
            idx = IDX_W'(TANH_TABLE_DEPTH - 1);
        else
            idx = idx_full[IDX_W-1:0];
        r = $signed(TANH_ROM[idx]);
        s2_th_next   = (z64 < 0) ? -r : r;
        s2_lapd_next = fkc_pkg::mul24(s1_lap_reg, $signed({1'b0, diff_gain_reg}), SB);
    end

    always_ff @(posedge clk)
    begin
        s2_u_reg     <= s1_u_reg;
        s2_above_reg <= s1_above_reg;
        s2_nv_reg    <= s2_nv_next;
        s2_nw_reg    <= s2_nw_next;
        s2_th_reg    <= s2_th_next;
        s2_lapd_reg  <= s2_lapd_next;
        s2_iso_reg   <= s1_iso_reg;
        s2_istim_reg <= s1_istim_reg;
    end

    // stage 3: first products of fast and slow inward currents
    logic               s3_above_reg;
    logic signed [31:0] s3_u_reg, s3_nv_reg, s3_nw_reg, s3_t1_reg, s3_ts1_reg;
    logic signed [31:0] s3_tsum_reg, s3_lapd_reg, s3_iso_reg, s3_istim_reg;

    always_ff @(posedge clk)
    begin
        s3_u_reg     <= s2_u_reg;
        s3_above_reg <= s2_above_reg;
        s3_nv_reg    <= s2_nv_reg;
        s3_nw_reg    <= s2_nw_reg;
        s3_t1_reg    <= fkc_pkg::mul24(s2_nv_reg, fkc_pkg::RATE_D, SB);
        s3_ts1_reg   <= fkc_pkg::mul24(s2_nw_reg, $signed({1'b0, rate_si_reg}), SB);
        s3_tsum_reg  <= fkc_pkg::sat_w(fkc_pkg::ONE_Q28 + 64'(s2_th_reg), SB);
        s3_lapd_reg  <= s2_lapd_reg;
        s3_iso_reg   <= s2_iso_reg;
        s3_istim_reg <= s2_istim_reg;
    end

    // stage 4: second products, slow inward current done
    logic signed [31:0] s4_t2_next, s4_ts2_next, s4_isi_next;
    logic               s4_above_reg;
    logic signed [31:0] s4_u_reg, s4_nv_reg, s4_nw_reg, s4_t2_reg, s4_isi_reg;
    logic signed [31:0] s4_lapd_reg, s4_iso_reg, s4_istim_reg;

    always_comb
    begin
        s4_t2_next  = fkc_pkg::mul28(s3_t1_reg,
                      fkc_pkg::sat_w(fkc_pkg::ONE_Q28 - 64'(s3_u_reg), SB), SB);
        s4_ts2_next = fkc_pkg::mul28(s3_ts1_reg, s3_tsum_reg, SB);
        s4_isi_next = fkc_pkg::sat_w(-(64'(s4_ts2_next) >>> 1), SB);
    end

    always_ff @(posedge clk)
    begin
        s4_u_reg     <= s3_u_reg;
        s4_above_reg <= s3_above_reg;
        s4_nv_reg    <= s3_nv_reg;
        s4_nw_reg    <= s3_nw_reg;
        s4_t2_reg    <= s4_t2_next;
        s4_isi_reg   <= s4_isi_next;
        s4_lapd_reg  <= s3_lapd_reg;
        s4_iso_reg   <= s3_iso_reg;
        s4_istim_reg <= s3_istim_reg;
    end

    // stage 5: last fast current product
    logic signed [31:0] s5_t3_next;
    logic signed [31:0] s5_u_reg, s5_nv_reg, s5_nw_reg, s5_ifi_reg, s5_isi_reg;
    logic signed [31:0] s5_lapd_reg, s5_iso_reg, s5_istim_reg;

    assign s5_t3_next = fkc_pkg::mul28(s4_t2_reg,
                        fkc_pkg::sat_w(64'(s4_u_reg) - fkc_pkg::U_C, SB), SB);

    always_ff @(posedge clk)
    begin
        s5_u_reg     <= s4_u_reg;
        s5_nv_reg    <= s4_nv_reg;
        s5_nw_reg    <= s4_nw_reg;
        s5_ifi_reg   <= s4_above_reg ? fkc_pkg::sat_w(-64'(s5_t3_next), SB) : 32'sd0;
        s5_isi_reg   <= s4_isi_reg;
        s5_lapd_reg  <= s4_lapd_reg;
        s5_iso_reg   <= s4_iso_reg;
        s5_istim_reg <= s4_istim_reg;
    end

    // stage 6: ionic current plus diffusion
    logic signed [31:0] s6_iion_next;
    logic signed [31:0] s6_u_reg, s6_nv_reg, s6_nw_reg, s6_du_reg;

    assign s6_iion_next = fkc_pkg::sat_w(-(64'(s5_ifi_reg) + 64'(s5_iso_reg)
                          + 64'(s5_isi_reg) + 64'(s5_istim_reg)), SB);

    always_ff @(posedge clk)
    begin
        s6_u_reg  <= s5_u_reg;
        s6_nv_reg <= s5_nv_reg;
        s6_nw_reg <= s5_nw_reg;
        s6_du_reg <= fkc_pkg::sat_w(64'(s6_iion_next) + 64'(s5_lapd_reg), SB);
    end

    // stage 7: potential step
    logic signed [31:0] s7_nu_reg, s7_nv_reg, s7_nw_reg;

    always_ff @(posedge clk)
    begin
        s7_nu_reg <= fkc_pkg::sat_w(64'(s6_u_reg)
                     + 64'(fkc_pkg::mul24(s6_du_reg, dt_s, SB)), SB);
        s7_nv_reg <= s6_nv_reg;
        s7_nw_reg <= s6_nw_reg;
    end

    // stage 8: mv scaling into the output registers
    logic signed [31:0] out_mv_next;
    logic signed [31:0] out_nu_reg, out_nv_reg, out_nw_reg, out_mv_reg;

    assign out_mv_next = fkc_pkg::sat_w(((fkc_pkg::SPAN_MV * 64'(s7_nu_reg)) >>> 12)
                         + fkc_pkg::REST_MV * 64'sd65536, SB);

    always_ff @(posedge clk)
    begin
        out_nu_reg <= s7_nu_reg;
        out_nv_reg <= s7_nv_reg;
        out_nw_reg <= s7_nw_reg;
        out_mv_reg <= out_mv_next;
    end

    assign new_potential = out_nu_reg;
    assign new_fast_gate = out_nv_reg;
    assign new_slow_gate = out_nw_reg;
    assign voltage_mv    = out_mv_reg;

endmodule

// ===== rtl/fkc_checker.sv =====
// port-level checks for the cable cell update pipeline, bound to the top level
module fkc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cfg_ready,
    input logic result_valid
);

    // every taken item gives a result strobe once it has passed the PIPE_DEPTH pipeline registers
    a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(fkc_pkg::PIPE_DEPTH) result_valid)
        else $error("taken item gave no result");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, fkc_pkg::PIPE_DEPTH))
        else $error("result without a taken item");

    a_no_result_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result right after reset");

    a_always_open: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("pipeline refused an item or a write");

endmodule

bind fenton_karma_cable_cell_update_top fkc_checker u_fkc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid)
);
